// ===== rtl/frqg_pkg.sv =====
// Shared types, codes and reset values for the frame rate quality governor.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package frqg_pkg;

    // Default history ring depth.
    localparam int HIST_DEPTH_DEFAULT = 128;

    // Field widths.
    localparam int TIME_W   = 24;
    localparam int RUN_W    = 8;
    localparam int PEN_W    = 8;
    localparam int BUDGET_W = 4;
    localparam int CLS_W    = 2;
    localparam int LEVEL_W  = 2;

    // Configuration bus widths.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Frame classes; the verdict uses the same codes (ok means no verdict).
    localparam logic [CLS_W-1:0] CLS_OK   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_SLOW = 2'd1;
    localparam logic [CLS_W-1:0] CLS_FAST = 2'd2;

    // Quality levels.
    localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd2;

    // Register reset values.
    localparam logic                RST_ENABLE       = 1'b1;
    localparam logic [TIME_W-1:0]   RST_FAST_LIMIT   = 24'd12500;
    localparam logic [TIME_W-1:0]   RST_SLOW_LIMIT   = 24'd34483;
    localparam logic [RUN_W-1:0]    RST_RUN_LENGTH   = 8'd10;
    localparam logic [PEN_W-1:0]    RST_SLOW_PENALTY = 8'd10;
    localparam logic [BUDGET_W-1:0] RST_GRANT_BUDGET = 4'd3;

    // Configuration seen by the sequencer.
    typedef struct packed {
        logic                enable;
        logic [TIME_W-1:0]   fast_limit_us;
        logic [TIME_W-1:0]   slow_limit_us;
        logic [RUN_W-1:0]    run_length;
        logic [PEN_W-1:0]    slow_penalty;
        logic [BUDGET_W-1:0] fast_grant_budget;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/frqg_ifs.sv =====
// Valid/ready channel interfaces for frame times in and governor results out.
// Depends on frqg_pkg for the field widths.
`default_nettype none

interface frqg_frame_if;
    logic                         valid;
    logic                         ready;
    logic [frqg_pkg::TIME_W-1:0]  frame_time_us;

    modport source (output valid, output frame_time_us, input ready);
    modport sink   (input valid, input frame_time_us, output ready);
endinterface

interface frqg_result_if;
    logic                         valid;
    logic                         ready;
    logic [frqg_pkg::CLS_W-1:0]   verdict;
    logic [frqg_pkg::LEVEL_W-1:0] level;
    logic                         changed;

    modport source (output valid, output verdict, output level, output changed, input ready);
    modport sink   (input valid, input verdict, input level, input changed, output ready);
endinterface

`default_nettype wire

// ===== rtl/frqg_regs.sv =====
// APB-style configuration register file of the governor.
// Depends on frqg_pkg for the register layout, widths and reset values.
`default_nettype none

module frqg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [frqg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [frqg_pkg::PDATA_W-1:0]  pwdata,
    output logic      [frqg_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output frqg_pkg::cfg_t                     cfg
);
    import frqg_pkg::*;

    // Register indexes (word address).
    localparam logic [2:0] REG_ENABLE     = 3'd0;
    localparam logic [2:0] REG_FAST_LIMIT = 3'd1;
    localparam logic [2:0] REG_SLOW_LIMIT = 3'd2;
    localparam logic [2:0] REG_RUN_LENGTH = 3'd3;
    localparam logic [2:0] REG_PENALTY    = 3'd4;
    localparam logic [2:0] REG_BUDGET     = 3'd5;

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= RST_ENABLE;
            cfg_reg.fast_limit_us     <= RST_FAST_LIMIT;
            cfg_reg.slow_limit_us     <= RST_SLOW_LIMIT;
            cfg_reg.run_length        <= RST_RUN_LENGTH;
            cfg_reg.slow_penalty      <= RST_SLOW_PENALTY;
            cfg_reg.fast_grant_budget <= RST_GRANT_BUDGET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLE:     cfg_reg.enable            <= pwdata[0];
                REG_FAST_LIMIT: cfg_reg.fast_limit_us     <= pwdata[TIME_W-1:0];
                REG_SLOW_LIMIT: cfg_reg.slow_limit_us     <= pwdata[TIME_W-1:0];
                REG_RUN_LENGTH: cfg_reg.run_length        <= pwdata[RUN_W-1:0];
                REG_PENALTY:    cfg_reg.slow_penalty      <= pwdata[PEN_W-1:0];
                REG_BUDGET:     cfg_reg.fast_grant_budget <= pwdata[BUDGET_W-1:0];
                default:        ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:     prdata = PDATA_W'(cfg_reg.enable);
            REG_FAST_LIMIT: prdata = PDATA_W'(cfg_reg.fast_limit_us);
            REG_SLOW_LIMIT: prdata = PDATA_W'(cfg_reg.slow_limit_us);
            REG_RUN_LENGTH: prdata = PDATA_W'(cfg_reg.run_length);
            REG_PENALTY:    prdata = PDATA_W'(cfg_reg.slow_penalty);
            REG_BUDGET:     prdata = PDATA_W'(cfg_reg.fast_grant_budget);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/frqg_hist.sv =====
// History ring memory: one write port, one read port with registered data.
// Depends on frqg_pkg for the class width.
`default_nettype none

module frqg_hist #(
    parameter int HISTORY_DEPTH = frqg_pkg::HIST_DEPTH_DEFAULT,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [AW-1:0]               waddr,
    input  wire logic [frqg_pkg::CLS_W-1:0]  wdata,
    input  wire logic [AW-1:0]               raddr,
    output logic      [frqg_pkg::CLS_W-1:0]  rdata
);
    import frqg_pkg::*;

    logic [CLS_W-1:0] mem [HISTORY_DEPTH];
    logic [CLS_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/frqg_ctrl.sv =====
// Sequencer of the governor: classifies a frame, walks the history ring with
// one shared accumulator, decides the verdict and sweeps the ring clear.
// Depends on frqg_pkg, the channel interfaces and the frqg_hist memory.
`default_nettype none

module frqg_ctrl #(
    parameter int HISTORY_DEPTH = frqg_pkg::HIST_DEPTH_DEFAULT,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire frqg_pkg::cfg_t              cfg,
    frqg_frame_if.sink                       frame,
    frqg_result_if.source                    result,
    output logic                             mem_we,
    output logic      [AW-1:0]               mem_waddr,
    output logic      [frqg_pkg::CLS_W-1:0]  mem_wdata,
    output logic      [AW-1:0]               mem_raddr,
    input  wire logic [frqg_pkg::CLS_W-1:0]  mem_rdata
);
    import frqg_pkg::*;

    // Widths derived from the ring depth.
    localparam int CNT_MAX = (HISTORY_DEPTH > 255) ? HISTORY_DEPTH : 255;
    localparam int CW      = $clog2(CNT_MAX + 1);
    localparam int GW      = $clog2(HISTORY_DEPTH + 1);
    localparam int TW      = $clog2(HISTORY_DEPTH * 256 + 1);
    localparam int ACW     = TW + 2;

    localparam logic [AW-1:0]       PTR_LAST  = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0]       CNT_DEPTH = CW'(HISTORY_DEPTH);
    localparam logic [BUDGET_W-1:0] GRANT_MAX = '1;

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RUN   = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_TOT   = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_DEC   = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       iss_reg, iss_next;
    logic [CW-1:0]       chk_reg, chk_next;
    logic                dv_reg, dv_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [GW-1:0]       good_reg, good_next;
    logic [ACW-1:0]      acc_reg, acc_next;
    logic [TW-1:0]       tot_reg, tot_next;
    logic [AW-1:0]       wp_reg, wp_next;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic [BUDGET_W-1:0] grants_reg, grants_next;
    logic [CLS_W-1:0]    verdict_reg, verdict_next;
    logic                emit_after_reg, emit_after_next;
    logic                out_vld_reg, out_vld_next;
    logic [CLS_W-1:0]    out_verdict_reg, out_verdict_next;
    logic [LEVEL_W-1:0]  out_level_reg, out_level_next;
    logic                out_changed_reg, out_changed_next;

    logic                frame_acc;
    logic [CLS_W-1:0]    cls_new;
    logic                judge_ok;
    logic [AW-1:0]       ptr_dec;
    logic [AW-1:0]       wp_inc;
    logic                issue;
    logic [ACW-1:0]      add_a, add_b, add_sum;
    logic                fast_pass, low_pass;
    logic [CLS_W-1:0]    dec_verdict;
    logic                out_free;

    assign frame.ready = (state_reg == S_IDLE);
    assign frame_acc   = frame.valid && (state_reg == S_IDLE);

    // Frame class; the fast test wins when the limits cross.
    always_comb
    begin
        if (frame.frame_time_us < cfg.fast_limit_us)
        begin
            cls_new = CLS_FAST;
        end
        else if (frame.frame_time_us >= cfg.slow_limit_us)
        begin
            cls_new = CLS_SLOW;
        end
        else
        begin
            cls_new = CLS_OK;
        end
    end

    // A class is judged only when the level has room to step that way.
    assign judge_ok = ((cls_new == CLS_FAST) && (level_reg != LEVEL_HIGH)) ||
                      ((cls_new == CLS_SLOW) && (level_reg != LEVEL_OFF));

    // Ring pointer arithmetic with explicit wrap.
    assign ptr_dec = (ptr_reg == '0) ? PTR_LAST : ptr_reg - 1'b1;
    assign wp_inc  = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;

    // The one shared adder.
    assign add_sum = add_a + add_b;

    // Share tests: 4*good > 3*total and 8*good > total.
    assign fast_pass = ACW'({good_reg, 2'b00}) > acc_reg;
    assign low_pass  = TW'({good_reg, 3'b000}) > tot_reg;

    always_comb
    begin
        if ((cls_reg == CLS_FAST) && fast_pass)
        begin
            dec_verdict = (grants_reg < cfg.fast_grant_budget) ? CLS_FAST : CLS_OK;
        end
        else if (low_pass)
        begin
            dec_verdict = cls_reg;
        end
        else
        begin
            dec_verdict = CLS_OK;
        end
    end

    assign out_free = !out_vld_reg || result.ready;

    // Sequencer next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        iss_next         = iss_reg;
        chk_next         = chk_reg;
        cls_next         = cls_reg;
        good_next        = good_reg;
        acc_next         = acc_reg;
        tot_next         = tot_reg;
        wp_next          = wp_reg;
        level_next       = level_reg;
        grants_next      = grants_reg;
        verdict_next     = verdict_reg;
        emit_after_next  = emit_after_reg;
        out_vld_next     = out_vld_reg && !result.ready;
        out_verdict_next = out_verdict_reg;
        out_level_next   = out_level_reg;
        out_changed_next = out_changed_reg;
        mem_we           = 1'b0;
        mem_waddr        = wp_reg;
        mem_wdata        = cls_new;
        mem_raddr        = ptr_reg;
        issue            = 1'b0;
        add_a            = acc_reg;
        add_b            = '0;

        unique case (state_reg)
            // Sweep the ring to ok, one entry a cycle.
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = CLS_OK;
                ptr_next  = ptr_dec;
                iss_next  = iss_reg - 1'b1;
                if (iss_reg == CW'(1))
                begin
                    state_next = emit_after_reg ? S_EMIT : S_IDLE;
                end
            end

            // Take a frame, record its class and choose the path.
            S_IDLE:
            begin
                if (frame_acc)
                begin
                    cls_next        = cls_new;
                    verdict_next    = CLS_OK;
                    emit_after_next = 1'b0;
                    if (!cfg.enable)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        mem_we  = 1'b1;
                        wp_next = wp_inc;
                        if (!judge_ok)
                        begin
                            state_next = S_EMIT;
                        end
                        else if (cfg.run_length == '0)
                        begin
                            ptr_next   = PTR_LAST;
                            iss_next   = CNT_DEPTH;
                            chk_next   = CNT_DEPTH;
                            good_next  = '0;
                            acc_next   = '0;
                            state_next = S_SUM;
                        end
                        else
                        begin
                            ptr_next   = wp_reg;
                            iss_next   = CW'(cfg.run_length);
                            chk_next   = CW'(cfg.run_length);
                            state_next = S_RUN;
                        end
                    end
                end
            end

            // Newest entries backward; any mismatch ends the judgement.
            S_RUN:
            begin
                issue = (iss_reg != '0);
                if (issue)
                begin
                    ptr_next = ptr_dec;
                    iss_next = iss_reg - 1'b1;
                end
                if (dv_reg)
                begin
                    chk_next = chk_reg - 1'b1;
                    if (mem_rdata != cls_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (chk_reg == CW'(1))
                    begin
                        ptr_next   = PTR_LAST;
                        iss_next   = CNT_DEPTH;
                        chk_next   = CNT_DEPTH;
                        good_next  = '0;
                        acc_next   = '0;
                        state_next = S_SUM;
                    end
                end
            end

            // Whole-ring walk: count matches, accumulate slow penalties.
            S_SUM:
            begin
                issue = (iss_reg != '0);
                if (issue)
                begin
                    ptr_next = ptr_dec;
                    iss_next = iss_reg - 1'b1;
                end
                if (dv_reg)
                begin
                    chk_next = chk_reg - 1'b1;
                    if (mem_rdata == cls_reg)
                    begin
                        good_next = good_reg + 1'b1;
                    end
                    if ((cls_reg == CLS_FAST) && (mem_rdata == CLS_SLOW))
                    begin
                        add_b = ACW'(cfg.slow_penalty);
                    end
                    acc_next = add_sum;
                    if (chk_reg == CW'(1))
                    begin
                        state_next = S_TOT;
                    end
                end
            end

            // Total weight: one unit per entry plus penalties.
            S_TOT:
            begin
                add_b      = ACW'(HISTORY_DEPTH);
                tot_next   = add_sum[TW-1:0];
                state_next = S_MUL;
            end

            // Three times the total for the three-quarter test.
            S_MUL:
            begin
                add_a      = ACW'({tot_reg, 1'b0});
                add_b      = ACW'(tot_reg);
                acc_next   = add_sum;
                state_next = S_DEC;
            end

            // Verdict, grant accounting and level step.
            S_DEC:
            begin
                if ((cls_reg == CLS_FAST) && fast_pass && (grants_reg != GRANT_MAX))
                begin
                    grants_next = grants_reg + 1'b1;
                end
                verdict_next = dec_verdict;
                if (dec_verdict == CLS_SLOW)
                begin
                    level_next = level_reg - 1'b1;
                end
                else if (dec_verdict == CLS_FAST)
                begin
                    level_next = level_reg + 1'b1;
                end
                if (dec_verdict != CLS_OK)
                begin
                    emit_after_next = 1'b1;
                    ptr_next        = PTR_LAST;
                    iss_next        = CNT_DEPTH;
                    state_next      = S_CLEAR;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            // Hand the word to the output register once it is free.
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next     = 1'b1;
                    out_verdict_next = verdict_reg;
                    out_level_next   = level_reg;
                    out_changed_next = (verdict_reg != CLS_OK);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign dv_next = issue;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ptr_reg        <= PTR_LAST;
            iss_reg        <= CNT_DEPTH;
            chk_reg        <= '0;
            dv_reg         <= 1'b0;
            wp_reg         <= '0;
            level_reg      <= LEVEL_HIGH;
            grants_reg     <= '0;
            emit_after_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            iss_reg        <= iss_next;
            chk_reg        <= chk_next;
            dv_reg         <= dv_next;
            wp_reg         <= wp_next;
            level_reg      <= level_next;
            grants_reg     <= grants_next;
            emit_after_reg <= emit_after_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Working and output data registers.
    always_ff @(posedge clk)
    begin
        cls_reg         <= cls_next;
        good_reg        <= good_next;
        acc_reg         <= acc_next;
        tot_reg         <= tot_next;
        verdict_reg     <= verdict_next;
        out_verdict_reg <= out_verdict_next;
        out_level_reg   <= out_level_next;
        out_changed_reg <= out_changed_next;
    end

    assign result.valid   = out_vld_reg;
    assign result.verdict = out_verdict_reg;
    assign result.level   = out_level_reg;
    assign result.changed = out_changed_reg;

    // The clearing sweep writes ok on every cycle it runs.
    a_clear_writes_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (mem_we && (mem_wdata == CLS_OK)))
        else $error("clearing sweep did not write ok");

    // Read data is only consumed after a read issued in a walk state.
    a_read_follows_walk: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (($past(state_reg) == S_RUN) || ($past(state_reg) == S_SUM)))
        else $error("read data valid without a walk");

    // The grant count never goes down.
    a_grants_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (grants_reg >= $past(grants_reg)))
        else $error("fast grant count decreased");

    // A level change always comes with a verdict.
    a_changed_has_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.changed) |-> (result.verdict != CLS_OK))
        else $error("level change without verdict");

endmodule

`default_nettype wire

// ===== rtl/frame_rate_quality_governor_unit.sv =====
// Frame rate quality governor: frame times in, quality verdicts out.
// Uses frqg_pkg, the channels in frqg_ifs, frqg_regs, frqg_hist, frqg_ctrl.
//
// Each word on the frame channel is one frame time in microseconds; each
// accepted word gives exactly one word on the result channel carrying the
// verdict (none, step down, step up), the quality level after the frame and
// a changed flag. Both channels transfer a word when valid and ready are high.
// Registers are to be written over the APB-style port while the block is idle; not enforced.
//
// One frame at a time is in flight. A disabled or unjudged frame goes from
// idle straight to the emit state, which hands its result word to the output
// register once that is free. A judged frame walks the history memory through
// its single read port: the run check over up to run_length entries, the share
// sum over the whole ring, the total, multiply and decide states for the share
// tests, plus a clearing sweep of the ring when a verdict is given.
// The next frame is taken while a result still waits in the output register;
// a stalled receiver holds the block once a second result is ready.
//
// After reset the block sweeps the whole history to ok before frame ready
// rises; register writes are accepted during the sweep.
`default_nettype none

module frame_rate_quality_governor_unit #(
    parameter int HISTORY_DEPTH = frqg_pkg::HIST_DEPTH_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [frqg_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [frqg_pkg::PDATA_W-1:0]  pwdata,
    output logic      [frqg_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    frqg_frame_if.sink                         frame,
    frqg_result_if.source                      result
);
    import frqg_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    cfg_t             cfg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [CLS_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [CLS_W-1:0] mem_rdata;

    // Configuration registers.
    frqg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // History ring memory.
    frqg_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer and shared accumulator.
    frqg_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .frame     (frame),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for frame_rate_quality_governor_unit.
// Needs frqg_pkg, the channel interfaces in frqg_ifs and the governor RTL.
// A directed table runs first, then phases of random frame-time sequences.

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import frqg_pkg::*;

    localparam int HIST_DEPTH       = HIST_DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES    = 600;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int DIR_ROWS         = 27;
    localparam int MIN_SHARE_RUN    = 17;

    localparam logic [BUDGET_W-1:0] GRANT_CEILING = '1;
    localparam logic [TIME_W-1:0]   TIME_MAX      = '1;

    // Register byte addresses.
    localparam logic [PADDR_W-1:0] ADDR_ENABLE       = 5'd0;
    localparam logic [PADDR_W-1:0] ADDR_FAST_LIMIT   = 5'd4;
    localparam logic [PADDR_W-1:0] ADDR_SLOW_LIMIT   = 5'd8;
    localparam logic [PADDR_W-1:0] ADDR_RUN_LENGTH   = 5'd12;
    localparam logic [PADDR_W-1:0] ADDR_SLOW_PENALTY = 5'd16;
    localparam logic [PADDR_W-1:0] ADDR_GRANT_BUDGET = 5'd20;

    typedef struct packed {
        logic [CLS_W-1:0]   verdict;
        logic [LEVEL_W-1:0] level;
        logic               changed;
    } result_t;

    typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [PADDR_W-1:0] addr;
        logic [PDATA_W-1:0] value;
        logic               typed;
        result_t            exp;
    } dir_row_t;

    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC
    } stall_mode_e;

    typedef enum int {
        PH_DEFAULTS, PH_DISABLED, PH_SHORT_RUN, PH_LONG_RUN, PH_ZERO_RUN, PH_WRAP_RUN,
        PH_CROSSED, PH_ALL_SLOW, PH_ALL_FAST, PH_RANDOM_A, PH_RANDOM_B, PH_COUNT
    } phase_e;

    localparam int PHASE_ITEMS [PH_COUNT] = '{120, 20, 100, 190, 100, 140, 100, 60, 80, 120, 120};

    localparam result_t STAY_HIGH = '{verdict: CLS_OK, level: LEVEL_HIGH, changed: 1'b0};
    localparam result_t NO_TYPED  = '0;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    frqg_frame_if  frame_bus ();
    frqg_result_if result_bus ();

    frame_rate_quality_governor_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .frame   (frame_bus),
        .result  (result_bus)
    );

    // Governor state mirrored by the testbench.
    cfg_t               gov_cfg;
    logic [CLS_W-1:0]   gov_hist [HIST_DEPTH];
    int                 gov_wp;
    logic [LEVEL_W-1:0] gov_level;
    logic [BUDGET_W-1:0] gov_grants;

    result_t pending_results [$];

    int errors;
    int frames_sent;
    int frames_ignored;
    int results_checked;
    int steps_down;
    int steps_up;
    int grants_refused;
    int burst_left;
    bit hold_request;

    // Directed stimulus: boundaries, the disabled case, a zero run length and a slow verdict.
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{ROW_FRAME, '0, 32'd0,             1'b1, STAY_HIGH},
        '{ROW_FRAME, '0, 32'h00FF_FFFF,     1'b1, STAY_HIGH},
        '{ROW_FRAME, '0, 32'd20000,         1'b1, STAY_HIGH},
        '{ROW_WRITE, ADDR_ENABLE, 32'd0,    1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h00FF_FFFF,     1'b1, STAY_HIGH},
        '{ROW_WRITE, ADDR_ENABLE, 32'd1,    1'b0, NO_TYPED},
        '{ROW_WRITE, ADDR_RUN_LENGTH, 32'd0, 1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'd34483,         1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h00FF_FFFF,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h00AA_AAAA,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h0055_5555,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h0080_0000,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h007F_FFFF,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h0000_FFFF,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h00FF_0000,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h000F_0F0F,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h00F0_F0F0,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h0012_3456,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h00FE_DCBA,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h003C_3C3C,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h00C3_C3C3,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'h0040_0000,     1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'd100000,        1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'd12499,         1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'd12500,         1'b0, NO_TYPED},
        '{ROW_FRAME, '0, 32'd34482,         1'b0, NO_TYPED},
        '{ROW_WRITE, ADDR_RUN_LENGTH, 32'd10, 1'b0, NO_TYPED}
    };

    // Clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Put the mirrored governor into its reset state.
    function automatic void governor_reset();
        gov_cfg.enable            = RST_ENABLE;
        gov_cfg.fast_limit_us     = RST_FAST_LIMIT;
        gov_cfg.slow_limit_us     = RST_SLOW_LIMIT;
        gov_cfg.run_length        = RST_RUN_LENGTH;
        gov_cfg.slow_penalty      = RST_SLOW_PENALTY;
        gov_cfg.fast_grant_budget = RST_GRANT_BUDGET;
        foreach (gov_hist[i]) gov_hist[i] = CLS_OK;
        gov_wp     = 0;
        gov_level  = LEVEL_HIGH;
        gov_grants = '0;
    endfunction

    // Run check over the newest entries, then the share test over the whole ring.
    function automatic logic [CLS_W-1:0] judge_window(input logic [CLS_W-1:0] cls);
        int newest;
        int idx;
        int i;
        int good;
        int bad;
        logic [BUDGET_W-1:0] used_before;
        newest = (gov_wp + HIST_DEPTH - 1) % HIST_DEPTH;
        for (i = 0; i < int'(gov_cfg.run_length); i++) begin
            idx = (newest + HIST_DEPTH - (i % HIST_DEPTH)) % HIST_DEPTH;
            if (gov_hist[idx] != cls)
                return CLS_OK;
        end
        good = 0;
        bad  = 0;
        for (i = 0; i < HIST_DEPTH; i++) begin
            if (gov_hist[i] == cls)
                good++;
            else
                bad++;
            if (cls == CLS_FAST && gov_hist[i] == CLS_SLOW)
                bad += int'(gov_cfg.slow_penalty);
        end
        // A high fast share spends a grant attempt and never falls back to the low path.
        if (cls == CLS_FAST && 4 * good > 3 * (good + bad)) begin
            used_before = gov_grants;
            if (gov_grants != GRANT_CEILING)
                gov_grants = gov_grants + 1'b1;
            if (used_before < gov_cfg.fast_grant_budget)
                return cls;
            grants_refused++;
            return CLS_OK;
        end
        if (8 * good > good + bad)
            return cls;
        return CLS_OK;
    endfunction

    // Expected result word for one frame time; updates the mirrored state.
    function automatic result_t predict_governor(input logic [TIME_W-1:0] t);
        result_t res;
        logic [CLS_W-1:0] cls;
        res.verdict = CLS_OK;
        res.level   = gov_level;
        res.changed = 1'b0;
        if (!gov_cfg.enable)
            return res;
        // The fast test wins even when the limits cross.
        if (t < gov_cfg.fast_limit_us)
            cls = CLS_FAST;
        else if (t >= gov_cfg.slow_limit_us)
            cls = CLS_SLOW;
        else
            cls = CLS_OK;
        gov_hist[gov_wp] = cls;
        gov_wp = (gov_wp + 1) % HIST_DEPTH;
        if ((cls == CLS_FAST && gov_level < LEVEL_HIGH) ||
            (cls == CLS_SLOW && gov_level != LEVEL_OFF))
            res.verdict = judge_window(cls);
        if (res.verdict != CLS_OK) begin
            foreach (gov_hist[i]) gov_hist[i] = CLS_OK;
            if (res.verdict == CLS_SLOW && gov_level != LEVEL_OFF) begin
                gov_level   = gov_level - 1'b1;
                res.changed = 1'b1;
                steps_down++;
            end
            else if (res.verdict == CLS_FAST && gov_level < LEVEL_HIGH) begin
                gov_level   = gov_level + 1'b1;
                res.changed = 1'b1;
                steps_up++;
            end
        end
        res.level = gov_level;
        return res;
    endfunction

    function automatic logic [TIME_W-1:0] random_time();
        logic [31:0] r;
        r = $urandom();
        return r[TIME_W-1:0];
    endfunction

    // Frame time that falls in the wanted class, often right on a limit.
    function automatic logic [TIME_W-1:0] time_for_class(input logic [CLS_W-1:0] cls);
        logic [31:0] fl;
        logic [31:0] sl;
        logic [31:0] r;
        bit edge_pick;
        fl = {8'd0, gov_cfg.fast_limit_us};
        sl = {8'd0, gov_cfg.slow_limit_us};
        edge_pick = ($urandom_range(0, 7) == 0);
        r = 32'(random_time());
        if (cls == CLS_FAST && fl != 0)
            r = edge_pick ? fl - 1 : $urandom_range(fl - 1, 0);
        else if (cls == CLS_SLOW)
            r = edge_pick ? sl : $urandom_range({8'd0, TIME_MAX}, sl);
        else if (cls == CLS_OK && sl > fl)
            r = edge_pick ? (($urandom_range(0, 1) == 0) ? fl : sl - 1)
                          : $urandom_range(sl - 1, fl);
        return r[TIME_W-1:0];
    endfunction

    function automatic cfg_t phase_config(input phase_e ph);
        cfg_t c;
        c.enable            = RST_ENABLE;
        c.fast_limit_us     = RST_FAST_LIMIT;
        c.slow_limit_us     = RST_SLOW_LIMIT;
        c.run_length        = RST_RUN_LENGTH;
        c.slow_penalty      = RST_SLOW_PENALTY;
        c.fast_grant_budget = RST_GRANT_BUDGET;
        case (ph)
            PH_DISABLED:
                c.enable = 1'b0;
            PH_SHORT_RUN: begin
                c.fast_limit_us     = 24'd5000;
                c.slow_limit_us     = 24'd6000;
                c.run_length        = 8'd1;
                c.slow_penalty      = 8'd0;
                c.fast_grant_budget = 4'd15;
            end
            PH_LONG_RUN: begin
                c.run_length        = 8'd100;
                c.slow_penalty      = 8'd0;
                c.fast_grant_budget = 4'd2;
            end
            PH_ZERO_RUN: begin
                c.run_length        = 8'd0;
                c.slow_penalty      = 8'd255;
                c.fast_grant_budget = 4'd0;
            end
            PH_WRAP_RUN: begin
                c.run_length        = 8'd255;
                c.slow_penalty      = 8'd1;
                c.fast_grant_budget = 4'd1;
            end
            PH_CROSSED: begin
                c.fast_limit_us = 24'd40000;
                c.slow_limit_us = 24'd20000;
                c.run_length    = 8'($urandom_range(2, 20));
            end
            PH_ALL_SLOW: begin
                c.fast_limit_us = 24'd0;
                c.slow_limit_us = 24'd0;
                c.run_length    = 8'd5;
            end
            PH_ALL_FAST: begin
                c.fast_limit_us     = TIME_MAX;
                c.slow_limit_us     = TIME_MAX;
                c.run_length        = 8'd3;
                c.slow_penalty      = 8'd255;
                c.fast_grant_budget = 4'd15;
            end
            PH_RANDOM_A, PH_RANDOM_B: begin
                c.fast_limit_us     = 24'($urandom_range(30000, 0));
                c.slow_limit_us     = 24'($urandom_range(60000, 0));
                c.run_length        = 8'($urandom_range(1, 40));
                c.slow_penalty      = 8'($urandom_range(0, 255));
                c.fast_grant_budget = 4'($urandom_range(0, 15));
            end
            default: ;
        endcase
        return c;
    endfunction

    // One APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_ENABLE:       gov_cfg.enable            = data[0];
            ADDR_FAST_LIMIT:   gov_cfg.fast_limit_us     = data[TIME_W-1:0];
            ADDR_SLOW_LIMIT:   gov_cfg.slow_limit_us     = data[TIME_W-1:0];
            ADDR_RUN_LENGTH:   gov_cfg.run_length        = data[RUN_W-1:0];
            ADDR_SLOW_PENALTY: gov_cfg.slow_penalty      = data[PEN_W-1:0];
            ADDR_GRANT_BUDGET: gov_cfg.fast_grant_budget = data[BUDGET_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_config(input cfg_t c);
        write_reg(ADDR_ENABLE,       {31'd0, c.enable});
        write_reg(ADDR_FAST_LIMIT,   {8'd0, c.fast_limit_us});
        write_reg(ADDR_SLOW_LIMIT,   {8'd0, c.slow_limit_us});
        write_reg(ADDR_RUN_LENGTH,   {24'd0, c.run_length});
        write_reg(ADDR_SLOW_PENALTY, {24'd0, c.slow_penalty});
        write_reg(ADDR_GRANT_BUDGET, {28'd0, c.fast_grant_budget});
    endtask

    // Stop offering, wait for every expected word, then let the block settle.
    task automatic wait_drained(input int settle);
        frame_bus.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // Offer one frame time in bursts with random gaps; record the expected word.
    task automatic send_frame(input logic [TIME_W-1:0] t, input logic typed,
                              input result_t typed_exp);
        result_t predicted;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 600)
                                               : $urandom_range(1, 12);
            frame_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 64);
        end
        frame_bus.valid         <= 1'b1;
        frame_bus.frame_time_us <= t;
        do @(posedge clk); while (!frame_bus.ready);
        burst_left--;
        frames_sent++;
        if (!gov_cfg.enable)
            frames_ignored++;
        predicted = predict_governor(t);
        pending_results.insert(pending_results.size(), typed ? typed_exp : predicted);
    endtask

    // Compare one accepted result word with the oldest expectation.
    task automatic check_result();
        result_t got;
        result_t want;
        got.verdict = result_bus.verdict;
        got.level   = result_bus.level;
        got.changed = result_bus.changed;
        if (pending_results.size() == 0) begin
            $display("%0t: result word with nothing expected: verdict %0d level %0d changed %0d",
                     $time, got.verdict, got.level, got.changed);
            errors++;
        end
        else begin
            want = pending_results.pop_front();
            results_checked++;
            if (got.verdict !== want.verdict) begin
                $display("%0t: verdict mismatch: expected %0d, got %0d",
                         $time, want.verdict, got.verdict);
                errors++;
            end
            if (got.level !== want.level) begin
                $display("%0t: level mismatch: expected %0d, got %0d",
                         $time, want.level, got.level);
                errors++;
            end
            if (got.changed !== want.changed) begin
                $display("%0t: changed mismatch: expected %0d, got %0d",
                         $time, want.changed, got.changed);
                errors++;
            end
        end
    endtask

    // Receiver: checks words and stalls on its own pattern, with one long hold-off on request.
    initial begin : result_sink
        stall_mode_e mode;
        int mode_left;
        int hold_left;
        result_bus.ready <= 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
                check_result();
            if (hold_request) begin
                hold_left    = LONG_HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = stall_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 256);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else begin
                case (mode)
                    STALL_NONE:     result_bus.ready <= 1'b1;
                    STALL_LIGHT:    result_bus.ready <= ($urandom_range(0, 3) != 0);
                    STALL_HEAVY:    result_bus.ready <= ($urandom_range(0, 3) == 0);
                    STALL_PERIODIC: result_bus.ready <= (mode_left % 5 == 0);
                    default:        result_bus.ready <= 1'b1;
                endcase
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((frame_bus.valid && frame_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Main stimulus.
    initial begin : stimulus
        int p;
        int k;
        int len;
        int sent;
        int r;
        int depth_run;
        bit noise;
        bit drained;
        logic [CLS_W-1:0] cls;
        logic [TIME_W-1:0] t;
        rst_n   <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        frame_bus.valid         <= 1'b0;
        frame_bus.frame_time_us <= '0;
        errors          = 0;
        frames_sent     = 0;
        frames_ignored  = 0;
        results_checked = 0;
        steps_down      = 0;
        steps_up        = 0;
        grants_refused  = 0;
        burst_left      = 0;
        hold_request    = 1'b0;
        drained         = 1'b0;
        governor_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows; register writes only once the block is idle.
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_drained(SETTLE_CYCLES);
                write_reg(directed_rows[i].addr, directed_rows[i].value);
            end
            else begin
                send_frame(directed_rows[i].value[TIME_W-1:0], directed_rows[i].typed,
                           directed_rows[i].exp);
            end
        end

        // Random phases: mostly same-class runs long enough to reach a verdict.
        for (p = 0; p < PH_COUNT; p++) begin
            wait_drained(SETTLE_CYCLES);
            apply_config(phase_config(phase_e'(p)));
            if (phase_e'(p) == PH_RANDOM_A)
                hold_request = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS[p]) begin
                if (phase_e'(p) == PH_RANDOM_B && !drained && sent > 50) begin
                    wait_drained(0);
                    drained = 1'b1;
                end
                r     = $urandom_range(0, 99);
                noise = (r < 12);
                cls   = CLS_OK;
                if (noise) begin
                    len = $urandom_range(1, 6);
                end
                else begin
                    if (r < 24)
                        cls = CLS_OK;
                    else if (gov_level == LEVEL_HIGH)
                        cls = (r < 80) ? CLS_SLOW : CLS_FAST;
                    else if (gov_level == LEVEL_OFF)
                        cls = (r < 80) ? CLS_FAST : CLS_SLOW;
                    else
                        cls = (r % 2 == 0) ? CLS_SLOW : CLS_FAST;
                    depth_run = (int'(gov_cfg.run_length) > HIST_DEPTH) ? HIST_DEPTH
                                                                         : int'(gov_cfg.run_length);
                    // A quarter of the runs are cut short of what a verdict needs.
                    if ($urandom_range(0, 3) == 0)
                        len = $urandom_range(1, (depth_run < 2) ? 2 : depth_run);
                    else
                        len = ((depth_run < MIN_SHARE_RUN) ? MIN_SHARE_RUN : depth_run)
                              + $urandom_range(0, 12);
                end
                for (k = 0; k < len && sent < PHASE_ITEMS[p]; k++) begin
                    t = noise ? random_time() : time_for_class(cls);
                    send_frame(t, 1'b0, NO_TYPED);
                    sent++;
                end
            end
        end

        wait_drained(SETTLE_CYCLES);
        $display("Sent %0d frame times (%0d while disabled) and checked %0d result words.",
                 frames_sent, frames_ignored, results_checked);
        $display("Quality stepped down %0d and up %0d times; %0d fast grants were refused.",
                 steps_down, steps_up, grants_refused);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
